[rtl/kde_pkg.sv]
// Package for the key debounce event FIFO: payload types, command codes,
// register indexes, event kinds and the event code function.
// No dependencies.
`timescale 1ns / 1ps

package kde_pkg;

    localparam int NUM_KEYS_DEF   = 2;
    localparam int FIFO_DEPTH_DEF = 16;

    localparam int CMD_W       = 2;
    localparam int KEYS_W      = 8;
    localparam int CODE_W      = 5;
    localparam int FILT_W      = 7;
    localparam int FCNT_W      = 8;
    localparam int LONG_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int KEY_NUM_W   = 3;
    localparam int EV_KIND_W   = 2;

    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 1'd1;

    localparam logic [EV_KIND_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EV_KIND_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EV_KIND_W-1:0] EV_LONG    = 2'd3;

    localparam logic [FILT_W-1:0] FILTER_TIME_RST     = 7'd5;
    localparam logic [LONG_W-1:0] LONG_PRESS_TIME_RST = 16'd100;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEYS_W-1:0] key_pressed;
    } kde_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              overflow;
    } kde_rsp_t;

    typedef struct packed {
        logic [FCNT_W-1:0] filter_count;
        logic              held_flag;
        logic [LONG_W-1:0] held_ticks;
    } key_state_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } push_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scan_status_t;

    function automatic logic [CODE_W-1:0] ev_code(input logic [KEY_NUM_W-1:0] key,
                                                  input logic [EV_KIND_W-1:0] kind);
        logic [CODE_W-1:0] k5;
        begin
            k5 = CODE_W'(key);
            ev_code = (k5 << 1) + k5 + CODE_W'(kind);
        end
    endfunction

endpackage

[rtl/kde_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on kde_pkg.
`timescale 1ns / 1ps

interface kde_req_if
    import kde_pkg::*;
();
    logic     valid;
    logic     ready;
    kde_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface kde_rsp_if
    import kde_pkg::*;
();
    logic     valid;
    logic     ready;
    kde_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/kde_key_scan.sv]
// Per-key debounce sequencer around the key state memory; at most one FIFO push per cycle.
// Walks the keys one per cycle, but pauses on a key with two events. Depends on kde_pkg.
`timescale 1ns / 1ps

module kde_key_scan
    import kde_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KEYS_W-1:0]  keys,
    input  logic [FILT_W-1:0]  filter_time,
    input  logic [LONG_W-1:0]  long_press_time,
    output push_t              push,
    output scan_status_t       status
);

    localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(NUM_KEYS - 1);

    localparam logic PH_CALC  = 1'b0;
    localparam logic PH_PUSH2 = 1'b1;

    key_state_t          kmem [NUM_KEYS];
    logic [NUM_KEYS-1:0] kvalid_reg;

    logic                busy_reg;
    logic                phase_reg;
    logic [KIDX_W-1:0]   key_idx_reg;
    logic [NUM_KEYS-1:0] keys_reg;
    logic [CODE_W-1:0]   ev2_code_reg;

    key_state_t          rd_raw_reg;
    key_state_t          fwd_data_reg;
    logic                rd_fwd_reg;
    logic                rd_valid_reg;

    key_state_t          cur;
    key_state_t          nxt;
    logic                pressed;
    logic [FCNT_W-1:0]   ft1;
    logic [FCNT_W-1:0]   ft2;
    logic [LONG_W:0]     ht_inc;
    logic                ev_press;
    logic                ev_rel;
    logic                ev_long;
    logic                calc;
    logic                last;
    logic                two_events;
    logic                advance;
    logic                done;
    logic                rd_en;
    logic [KIDX_W-1:0]   rd_addr;
    logic [KEY_NUM_W-1:0] key_num;

    assign calc    = busy_reg && (phase_reg == PH_CALC);
    assign last    = (key_idx_reg == LAST_KEY);
    assign pressed = keys_reg[key_idx_reg];
    assign key_num = KEY_NUM_W'(key_idx_reg);
    assign ft1     = {1'b0, filter_time};
    assign ft2     = {filter_time, 1'b0};
    assign ht_inc  = {1'b0, cur.held_ticks} + (LONG_W+1)'(1);
    assign cur     = rd_fwd_reg ? fwd_data_reg : (rd_valid_reg ? rd_raw_reg : '0);

    always_comb
    begin
        nxt      = cur;
        ev_press = 1'b0;
        ev_rel   = 1'b0;
        ev_long  = 1'b0;
        if (pressed)
        begin
            if (cur.filter_count < ft1)
            begin
                nxt.filter_count = ft1;
            end
            else if (cur.filter_count < ft2)
            begin
                nxt.filter_count = cur.filter_count + FCNT_W'(1);
            end
            else
            begin
                if (!cur.held_flag)
                begin
                    nxt.held_flag = 1'b1;
                    ev_press      = 1'b1;
                end
                if ((long_press_time != '0) && (cur.held_ticks < long_press_time))
                begin
                    nxt.held_ticks = ht_inc[LONG_W-1:0];
                    ev_long        = (ht_inc[LONG_W-1:0] == long_press_time);
                end
            end
        end
        else
        begin
            if (cur.filter_count > ft1)
            begin
                nxt.filter_count = ft1;
            end
            else if (cur.filter_count != '0)
            begin
                nxt.filter_count = cur.filter_count - FCNT_W'(1);
            end
            else if (cur.held_flag)
            begin
                nxt.held_flag = 1'b0;
                ev_rel        = 1'b1;
            end
            nxt.held_ticks = '0;
        end
    end

    assign two_events = ev_press && ev_long;
    assign advance    = (calc && !two_events) || (busy_reg && (phase_reg == PH_PUSH2));
    assign done       = advance && last;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (start)
        begin
            rd_en = 1'b1;
        end
        else if (advance && !last)
        begin
            rd_en   = 1'b1;
            rd_addr = key_idx_reg + KIDX_W'(1);
        end
    end

    always_comb
    begin
        push = '0;
        if (calc)
        begin
            push.valid = ev_press || ev_rel || ev_long;
            if (ev_press)
            begin
                push.code = ev_code(key_num, EV_PRESS);
            end
            else if (ev_rel)
            begin
                push.code = ev_code(key_num, EV_RELEASE);
            end
            else
            begin
                push.code = ev_code(key_num, EV_LONG);
            end
        end
        else if (busy_reg)
        begin
            push.valid = 1'b1;
            push.code  = ev2_code_reg;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done;

    always_ff @(posedge clk)
    begin
        if (calc)
        begin
            kmem[key_idx_reg] <= nxt;
        end
        if (rd_en)
        begin
            rd_raw_reg   <= kmem[rd_addr];
            fwd_data_reg <= nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kvalid_reg   <= '0;
            busy_reg     <= 1'b0;
            phase_reg    <= PH_CALC;
            key_idx_reg  <= '0;
            keys_reg     <= '0;
            ev2_code_reg <= '0;
            rd_fwd_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (calc)
            begin
                kvalid_reg[key_idx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_fwd_reg   <= calc && (key_idx_reg == rd_addr);
                rd_valid_reg <= kvalid_reg[rd_addr];
            end
            if (start)
            begin
                busy_reg    <= 1'b1;
                phase_reg   <= PH_CALC;
                key_idx_reg <= '0;
                keys_reg    <= keys[NUM_KEYS-1:0];
            end
            else if (done)
            begin
                busy_reg  <= 1'b0;
                phase_reg <= PH_CALC;
            end
            else if (advance)
            begin
                phase_reg   <= PH_CALC;
                key_idx_reg <= key_idx_reg + KIDX_W'(1);
            end
            else if (calc)
            begin
                phase_reg    <= PH_PUSH2;
                ev2_code_reg <= ev_code(key_num, EV_LONG);
            end
        end
    end

endmodule

[rtl/kde_event_fifo.sv]
// Ring FIFO of event codes in a synchronous memory, with the sticky overflow
// flag and the response register. Depends on kde_pkg and kde_rsp_if.
`timescale 1ns / 1ps

module kde_event_fifo
    import kde_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    input  logic        get,
    input  logic        clear,
    output logic        out_free,
    kde_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    logic [CODE_W-1:0] fmem [FIFO_DEPTH];

    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W-1:0]  wptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;

    logic              out_valid_reg;
    logic              out_empty_reg;
    logic              out_fwd_reg;
    logic              out_ovf_reg;
    logic [CODE_W-1:0] fwd_code_reg;
    logic [CODE_W-1:0] rd_data_reg;

    logic              push_ok;
    logic              pop;
    logic              ovf_after;
    logic [CNT_W-1:0]  count_after;

    assign push_ok     = push.valid && (count_reg != FULL_CNT);
    assign ovf_after   = ovf_reg || (push.valid && !push_ok);
    assign count_after = count_reg + CNT_W'(push_ok);
    assign pop         = get && (count_after != '0);
    assign out_free    = !out_valid_reg || rsp.ready;

    assign rsp.valid              = out_valid_reg;
    assign rsp.payload.overflow   = out_ovf_reg;
    assign rsp.payload.event_code = out_empty_reg ? '0 :
                                    (out_fwd_reg ? fwd_code_reg : rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fmem[wptr_reg] <= push.code;
        end
        if (get)
        begin
            rd_data_reg  <= fmem[rptr_reg];
            fwd_code_reg <= push.code;
            out_ovf_reg  <= ovf_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_empty_reg <= 1'b1;
            out_fwd_reg   <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                rptr_reg  <= '0;
                wptr_reg  <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                ovf_reg   <= ovf_after;
                count_reg <= count_after - CNT_W'(pop);
                if (push_ok)
                begin
                    wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
                end
                if (pop)
                begin
                    rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
                end
            end
            if (get)
            begin
                out_valid_reg <= 1'b1;
                out_empty_reg <= (count_after == '0);
                out_fwd_reg   <= (count_reg == '0);
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/key_debounce_event_fifo.sv]
// Key debounce with long-press detection and an event FIFO. A scan request
// walks the key state memory one key per cycle, pausing on each key that
// raises a press and a long-press event in the same tick; the next request is
// taken in the scan's last cycle. A get result sits in an output register
// while further scan and clear requests are accepted; a further get is held
// off until that result is taken. Depends on kde_pkg, kde_if, kde_key_scan
// and kde_event_fifo.
`timescale 1ns / 1ps

module key_debounce_event_fifo
    import kde_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    kde_req_if.sink               req,
    kde_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FILT_W-1:0] filter_time_reg;
    logic [LONG_W-1:0] long_press_time_reg;

    scan_status_t      scan_status;
    push_t             push;
    logic              out_free;
    logic              can_start;
    logic              accept;
    logic              start_scan;
    logic              get;
    logic              clear;

    assign can_start  = !scan_status.busy || scan_status.done;
    assign req.ready  = can_start && ((req.payload.cmd != CMD_GET) || out_free);
    assign accept     = req.valid && req.ready;
    assign start_scan = accept && (req.payload.cmd == CMD_SCAN);
    assign get        = accept && (req.payload.cmd == CMD_GET);
    assign clear      = accept && (req.payload.cmd == CMD_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg     <= FILTER_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_TIME:     filter_time_reg     <= cfg_data[FILT_W-1:0];
                CFG_LONG_PRESS_TIME: long_press_time_reg <= cfg_data[LONG_W-1:0];
                default:             ;
            endcase
        end
    end

    kde_key_scan #(
        .NUM_KEYS (NUM_KEYS)
    ) u_key_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start_scan),
        .keys            (req.payload.key_pressed),
        .filter_time     (filter_time_reg),
        .long_press_time (long_press_time_reg),
        .push            (push),
        .status          (scan_status)
    );

    kde_event_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_event_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .get      (get),
        .clear    (clear),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule

[test/tb_key_debounce_event_fifo.sv]
// Self-checking testbench for key_debounce_event_fifo: drives scan, get, clear and unused
// requests, predicts debounce and event FIFO behavior, and checks every get result.
// Depends on kde_pkg, kde_if and the key_debounce_event_fifo RTL.
`timescale 1ns / 1ps

module tb_key_debounce_event_fifo;
    import kde_pkg::*;

    localparam int KEYS        = NUM_KEYS_DEF;
    localparam int DEPTH       = FIFO_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kde_req_if req_ch();
    kde_rsp_if rsp_ch();

    key_debounce_event_fifo i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [FILT_W-1:0] filter_time_m;
    logic [LONG_W-1:0] long_press_time_m;
    logic [FCNT_W-1:0] filter_cnt_m [KEYS];
    logic              held_m [KEYS];
    logic [LONG_W-1:0] held_ticks_m [KEYS];
    logic [CODE_W-1:0] event_fifo_m [$];
    logic              overflow_m;

    kde_req_t pending_reqs [$];
    kde_rsp_t expected_gets [$];
    kde_rsp_t rsp_got;
    kde_rsp_t rsp_want;

    int reqs_queued;
    int reqs_taken;
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_armed;
    bit req_fire;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void reset_model();
        filter_time_m     = FILTER_TIME_RST;
        long_press_time_m = LONG_PRESS_TIME_RST;
        for (int k = 0; k < KEYS; k++)
        begin
            filter_cnt_m[k] = '0;
            held_m[k]       = 1'b0;
            held_ticks_m[k] = '0;
        end
        event_fifo_m.delete();
        overflow_m = 1'b0;
    endfunction

    function automatic void log_event(input int key, input logic [EV_KIND_W-1:0] kind);
        if (event_fifo_m.size() >= DEPTH)
            overflow_m = 1'b1;
        else
            event_fifo_m.push_back(CODE_W'(3 * key + int'(kind)));
    endfunction

    function automatic void filter_key(input int key, input logic pressed);
        int ft;
        ft = int'(filter_time_m);
        if (pressed)
        begin
            if (int'(filter_cnt_m[key]) < ft)
                filter_cnt_m[key] = FCNT_W'(ft);
            else if (int'(filter_cnt_m[key]) < 2 * ft)
                filter_cnt_m[key] = filter_cnt_m[key] + FCNT_W'(1);
            else
            begin
                if (!held_m[key])
                begin
                    held_m[key] = 1'b1;
                    log_event(key, EV_PRESS);
                end
                if (long_press_time_m != '0 && held_ticks_m[key] < long_press_time_m)
                begin
                    held_ticks_m[key] = held_ticks_m[key] + LONG_W'(1);
                    if (held_ticks_m[key] == long_press_time_m)
                        log_event(key, EV_LONG);
                end
            end
        end
        else
        begin
            if (int'(filter_cnt_m[key]) > ft)
                filter_cnt_m[key] = FCNT_W'(ft);
            else if (filter_cnt_m[key] != '0)
                filter_cnt_m[key] = filter_cnt_m[key] - FCNT_W'(1);
            else if (held_m[key])
            begin
                held_m[key] = 1'b0;
                log_event(key, EV_RELEASE);
            end
            held_ticks_m[key] = '0;
        end
    endfunction

    function automatic void apply_request(input kde_req_t r);
        kde_rsp_t want;
        case (r.cmd)
            CMD_SCAN:
            begin
                for (int k = 0; k < KEYS; k++)
                    filter_key(k, r.key_pressed[k]);
            end
            CMD_GET:
            begin
                want.event_code = (event_fifo_m.size() != 0) ? event_fifo_m.pop_front() : '0;
                want.overflow   = overflow_m;
                expected_gets.push_back(want);
            end
            CMD_CLEAR:
            begin
                event_fifo_m.delete();
                overflow_m = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void push_req(input logic [CMD_W-1:0] c, input logic [KEYS_W-1:0] k);
        kde_req_t r;
        r.cmd         = c;
        r.key_pressed = k;
        pending_reqs.push_back(r);
        reqs_queued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (reqs_taken != reqs_queued || expected_gets.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Keys hold one pattern for runs up to a length that passes the filter and reaches a
    // long-press time below 40, with gets, clears, unused commands and bounces mixed in.
    task automatic queue_random(input int count, input int get_pct);
        int left;
        int run;
        int max_run;
        int roll;
        int bounce_pct;
        logic [KEYS_W-1:0] keys;
        left       = count;
        bounce_pct = (filter_time_m < 64) ? 5 : 0;
        max_run    = (2 * int'(filter_time_m) + 6
                      + ((long_press_time_m < 40) ? int'(long_press_time_m) : 0)) * 3 / 2;
        while (left > 0)
        begin
            keys = KEYS_W'($urandom_range(0, 255));
            run  = $urandom_range(0, 1) ? max_run : $urandom_range(1, max_run);
            while (run > 0 && left > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < get_pct)
                    push_req(CMD_GET, KEYS_W'($urandom));
                else if (roll < get_pct + 2)
                    push_req(CMD_CLEAR, KEYS_W'($urandom));
                else if (roll < get_pct + 4)
                begin
                    push_req(CMD_UNUSED, KEYS_W'($urandom));
                    left++;
                end
                else if (roll < get_pct + 4 + bounce_pct)
                    push_req(CMD_SCAN, keys ^ (KEYS_W'(1) << $urandom_range(0, KEYS_W - 1)));
                else
                    push_req(CMD_SCAN, keys);
                run--;
                left--;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_ch.payload <= pending_reqs.pop_front();
                req_ch.valid   <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left = hold_left - 1;
        else if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_model();
            req_fire = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FILTER_TIME)
                    filter_time_m = cfg_data[FILT_W-1:0];
                else if (cfg_index == CFG_LONG_PRESS_TIME)
                    long_press_time_m = cfg_data[LONG_W-1:0];
            end
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
            begin
                apply_request(req_ch.payload);
                reqs_taken++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_got = rsp_ch.payload;
                if (expected_gets.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, actual code %0d overflow %0b",
                             $time, rsp_got.event_code, rsp_got.overflow);
                end
                else
                begin
                    rsp_want = expected_gets.pop_front();
                    if (rsp_got.event_code !== rsp_want.event_code)
                    begin
                        errors++;
                        $display("%0t: event_code expected %0d, actual %0d",
                                 $time, rsp_want.event_code, rsp_got.event_code);
                    end
                    if (rsp_got.overflow !== rsp_want.overflow)
                    begin
                        errors++;
                        $display("%0t: overflow expected %0b, actual %0b",
                                 $time, rsp_want.overflow, rsp_got.overflow);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_key_debounce_event_fifo: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        reqs_queued    = 0;
        reqs_taken     = 0;
        errors         = 0;
        cycles         = 0;
        hold_left      = 0;
        hold_armed     = 1'b0;
        req_fire       = 1'b0;
        send_idle_pct  = 30;
        recv_stall_pct = 47;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_req(CMD_GET, 8'h00);
        push_req(CMD_UNUSED, 8'hFF);
        push_req(CMD_CLEAR, 8'h00);
        push_req(CMD_GET, 8'h5A);
        settle();

        write_reg(CFG_FILTER_TIME, 16'hFF81);
        write_reg(CFG_LONG_PRESS_TIME, 16'd2);
        repeat (4) push_req(CMD_SCAN, 8'hFF);
        repeat (3) push_req(CMD_SCAN, 8'hFC);
        repeat (7) push_req(CMD_GET, 8'h00);
        settle();

        write_reg(CFG_FILTER_TIME, 16'h0000);
        write_reg(CFG_LONG_PRESS_TIME, 16'h0000);
        push_req(CMD_SCAN, 8'h01);
        push_req(CMD_SCAN, 8'h00);
        push_req(CMD_SCAN, 8'h02);
        repeat (4) push_req(CMD_GET, 8'h00);
        settle();

        write_reg(CFG_FILTER_TIME, 16'd1);
        write_reg(CFG_LONG_PRESS_TIME, 16'd1);
        repeat (3)
        begin
            repeat (3) push_req(CMD_SCAN, 8'h03);
            repeat (3) push_req(CMD_SCAN, 8'h00);
        end
        repeat (18) push_req(CMD_GET, 8'h00);
        push_req(CMD_CLEAR, 8'h00);
        push_req(CMD_GET, 8'h00);
        settle();

        write_reg(CFG_FILTER_TIME, 16'd3);
        write_reg(CFG_LONG_PRESS_TIME, 16'd10);
        queue_random(300, 15);
        settle();

        send_idle_pct  = 47;
        recv_stall_pct = 30;
        write_reg(CFG_FILTER_TIME, 16'h7F7F);
        write_reg(CFG_LONG_PRESS_TIME, 16'hFFFF);
        queue_random(400, 10);
        settle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_FILTER_TIME, 16'd2);
        write_reg(CFG_LONG_PRESS_TIME, 16'd5);
        hold_armed = 1'b1;
        queue_random(200, 30);
        settle();

        write_reg(CFG_FILTER_TIME, 16'd4);
        write_reg(CFG_LONG_PRESS_TIME, 16'd0);
        queue_random(200, 8);
        settle();

        if (errors == 0)
            $display("tb_key_debounce_event_fifo: clean");
        else
            $display("tb_key_debounce_event_fifo: errors");
        $finish;
    end

endmodule
